// ----- hw/rtl/interval_set_insert_merge_assert.svh -----
// Assertion macros for the interval set insert and merge block.
`ifndef INTERVAL_SET_INSERT_MERGE_ASSERT_SVH
`define INTERVAL_SET_INSERT_MERGE_ASSERT_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define ISIM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition in one cycle implies another in the next.
`define ISIM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ISIM_ASSERT(lbl, prop, msg)
`define ISIM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/isim_pkg.sv -----
// Shared types and constants of the interval set insert and merge block.
`timescale 1ns / 1ps
package isim_pkg;

  localparam int unsigned TableDepthDef = 16;
  localparam int unsigned MaxResults    = 16;
  localparam int unsigned DataW         = 32;
  localparam int unsigned IndexW        = 4;
  localparam int unsigned TotalW        = 5;

  typedef enum logic [1:0] {
    StInserted = 2'd0,
    StCovered  = 2'd1,
    StFull     = 2'd2,
    StRejected = 2'd3
  } status_e;

  // Flags from the shared compare unit.
  typedef struct packed {
    logic end_lt_ns;   // entry end below new start
    logic start_le_ne; // entry start at or below new end
    logic start_le_ns; // entry start at or below new start
    logic end_ge_ne;   // entry end at or above new end
  } cmp_t;

endpackage

// ----- hw/rtl/isim_cmp.sv -----
// Shared compare unit: orders one stored interval against the request interval.
`timescale 1ns / 1ps
module isim_cmp (
  input  logic signed [isim_pkg::DataW-1:0] ent_start_i,
  input  logic signed [isim_pkg::DataW-1:0] ent_end_i,
  input  logic signed [isim_pkg::DataW-1:0] new_start_i,
  input  logic signed [isim_pkg::DataW-1:0] new_end_i,
  output isim_pkg::cmp_t                    cmp_o,
  output logic signed [isim_pkg::DataW-1:0] min_start_o,
  output logic signed [isim_pkg::DataW-1:0] max_end_o
);

  always_comb begin
    cmp_o.end_lt_ns   = ent_end_i < new_start_i;
    cmp_o.start_le_ne = ent_start_i <= new_end_i;
    cmp_o.start_le_ns = ent_start_i <= new_start_i;
    cmp_o.end_ge_ne   = ent_end_i >= new_end_i;
    min_start_o       = cmp_o.start_le_ns ? ent_start_i : new_start_i;
    max_end_o         = cmp_o.end_ge_ne ? ent_end_i : new_end_i;
  end

endmodule

// ----- hw/rtl/interval_set_insert_merge.sv -----
// Top level of the interval set insert and merge block.
`timescale 1ns / 1ps
`include "interval_set_insert_merge_assert.svh"
// Keeps a sorted list of disjoint closed intervals in a table of TableDepth
// entries with one read and one write port. A request is taken when start is
// high and busy is low; busy then stays high until the dump is complete and
// falls in the cycle that shows the last result. Each result is shown for
// exactly one cycle with strobe_o high and cannot be held off, so the receiver
// must take it on that edge. While busy, the block works through the one table
// read port: it scans the table for the overlap window and decides, then either
// shifts the entries up and places the new entry (insert) or places the merged
// entry and compacts the entries behind it (merge), and then dumps the list. A
// rejected request, a covered one or one that meets a full table goes straight
// to the dump.
// There is no clearing pass after reset; the list simply starts empty.
module interval_set_insert_merge #(
  parameter int unsigned TableDepth = isim_pkg::TableDepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [isim_pkg::DataW-1:0] new_start_i,
  input  logic signed [isim_pkg::DataW-1:0] new_end_i,
  output logic                              strobe_o,
  output logic [isim_pkg::IndexW-1:0]       entry_index_o,
  output logic signed [isim_pkg::DataW-1:0] entry_start_o,
  output logic signed [isim_pkg::DataW-1:0] entry_end_o,
  output logic [isim_pkg::TotalW-1:0]       entry_total_o,
  output logic [1:0]                        status_o,
  output logic                              last_o
);

  localparam int unsigned IW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CW = $clog2(TableDepth + 1);
  localparam int unsigned DW = isim_pkg::DataW;

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_PLACE  = 3'd4;
  localparam logic [2:0] S_COPY   = 3'd5;
  localparam logic [2:0] S_DUMP   = 3'd6;

  logic [2:0] state_q, state_d;

  // Interval table: start in the upper half, end in the lower half.
  logic [2*DW-1:0] ivl_mem_q [TableDepth];
  logic [2*DW-1:0] rd_q;
  logic [IW-1:0]   raddr;
  logic [IW-1:0]   waddr;
  logic [2*DW-1:0] wdata;
  logic            we;

  // Control and working registers.
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d;       // next read index
  logic [CW-1:0]   wtgt_q, wtgt_d;     // write target or index of pending read
  logic [CW-1:0]   first_q, first_d;   // entries entirely below the request
  logic [CW-1:0]   past_q, past_d;     // entries starting at or below request end
  logic            pend_q, pend_d;     // read data in rd_q belongs to a read issued
  logic            found_q, found_d;   // first overlapping entry seen
  logic            merge_q, merge_d;   // place step belongs to a merge
  logic signed [DW-1:0] ns_q, ns_d;
  logic signed [DW-1:0] ne_q, ne_d;
  logic signed [DW-1:0] fs_q, fs_d;    // start of first overlap, then placed start
  logic signed [DW-1:0] le_q, le_d;    // end of last overlap, then placed end
  isim_pkg::status_e    status_q, status_d;

  // Result registers.
  logic                        strobe_q, strobe_d;
  logic [isim_pkg::IndexW-1:0] oidx_q, oidx_d;
  logic signed [DW-1:0]        ostart_q, ostart_d;
  logic signed [DW-1:0]        oend_q, oend_d;
  logic [isim_pkg::TotalW-1:0] ototal_q, ototal_d;
  logic [1:0]                  ostat_q, ostat_d;
  logic                        olast_q, olast_d;

  // Shared compare unit.
  logic signed [DW-1:0] rd_start, rd_end;
  logic signed [DW-1:0] cmp_start, cmp_end;
  logic signed [DW-1:0] min_start, max_end;
  isim_pkg::cmp_t       cmp;

  logic [CW-1:0] absorbed;
  logic [CW-1:0] dump_n;

  assign rd_start = rd_q[2*DW-1:DW];
  assign rd_end   = rd_q[DW-1:0];

  // Feed the held overlap bounds while deciding, the table read otherwise.
  assign cmp_start = (state_q == S_DECIDE) ? fs_q : rd_start;
  assign cmp_end   = (state_q == S_DECIDE) ? le_q : rd_end;

  isim_cmp u_cmp (
    .ent_start_i (cmp_start),
    .ent_end_i   (cmp_end),
    .new_start_i (ns_q),
    .new_end_i   (ne_q),
    .cmp_o       (cmp),
    .min_start_o (min_start),
    .max_end_o   (max_end)
  );

  assign absorbed = past_q - first_q;
  assign dump_n   = (32'(count_q) > isim_pkg::MaxResults) ? CW'(isim_pkg::MaxResults)
                                                          : count_q;

  // Table: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we) begin
      ivl_mem_q[waddr] <= wdata;
    end
    rd_q <= ivl_mem_q[raddr];
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    wtgt_d   = wtgt_q;
    first_d  = first_q;
    past_d   = past_q;
    pend_d   = 1'b0;
    found_d  = found_q;
    merge_d  = merge_q;
    ns_d     = ns_q;
    ne_d     = ne_q;
    fs_d     = fs_q;
    le_d     = le_q;
    status_d = status_q;

    strobe_d = 1'b0;
    oidx_d   = oidx_q;
    ostart_d = ostart_q;
    oend_d   = oend_q;
    ototal_d = ototal_q;
    ostat_d  = ostat_q;
    olast_d  = olast_q;

    raddr = idx_q[IW-1:0];
    waddr = wtgt_q[IW-1:0];
    wdata = rd_q;
    we    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          ns_d    = new_start_i;
          ne_d    = new_end_i;
          idx_d   = '0;
          first_d = '0;
          past_d  = '0;
          found_d = 1'b0;
          if (new_start_i > new_end_i) begin
            status_d = isim_pkg::StRejected;
            state_d  = S_DUMP;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      // Stream the list through the compare unit to find the overlap window.
      S_SCAN: begin
        if (pend_q) begin
          if (cmp.end_lt_ns) begin
            first_d = first_q + 1'b1;
          end else if (!found_q) begin
            found_d = 1'b1;
            fs_d    = rd_start;
          end
          if (cmp.start_le_ne) begin
            past_d = past_q + 1'b1;
            le_d   = rd_end;
          end
        end
        if (idx_q != count_q) begin
          idx_d  = idx_q + 1'b1;
          pend_d = 1'b1;
        end else begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        idx_d = '0;
        if (absorbed == '0) begin
          if (count_q == CW'(TableDepth)) begin
            status_d = isim_pkg::StFull;
            state_d  = S_DUMP;
          end else begin
            status_d = isim_pkg::StInserted;
            merge_d  = 1'b0;
            fs_d     = ns_q;
            le_d     = ne_q;
            idx_d    = count_q;
            state_d  = S_SHIFT;
          end
        end else if (absorbed == CW'(1) && cmp.start_le_ns && cmp.end_ge_ne) begin
          status_d = isim_pkg::StCovered;
          state_d  = S_DUMP;
        end else begin
          status_d = isim_pkg::StInserted;
          merge_d  = 1'b1;
          fs_d     = min_start;
          le_d     = max_end;
          state_d  = S_PLACE;
        end
      end

      // Move entries up by one, from the tail down to the insert point.
      S_SHIFT: begin
        raddr = IW'(idx_q - 1'b1);
        if (pend_q) begin
          we = 1'b1;
        end
        if (idx_q != first_q) begin
          wtgt_d = idx_q;
          idx_d  = idx_q - 1'b1;
          pend_d = 1'b1;
        end else begin
          state_d = S_PLACE;
        end
      end

      S_PLACE: begin
        we    = 1'b1;
        waddr = first_q[IW-1:0];
        wdata = {fs_q, le_q};
        if (merge_q) begin
          idx_d   = past_q;
          wtgt_d  = first_q + 1'b1;
          state_d = S_COPY;
        end else begin
          count_d = count_q + 1'b1;
          idx_d   = '0;
          state_d = S_DUMP;
        end
      end

      // Pull the entries behind the absorbed run down behind the merged one.
      S_COPY: begin
        if (pend_q) begin
          we     = 1'b1;
          wtgt_d = wtgt_q + 1'b1;
        end
        if (idx_q != count_q) begin
          idx_d  = idx_q + 1'b1;
          pend_d = 1'b1;
        end else begin
          count_d = count_q - past_q + first_q + 1'b1;
          idx_d   = '0;
          state_d = S_DUMP;
        end
      end

      // Emit the list in order, or one empty result for an empty list.
      S_DUMP: begin
        if (count_q == '0) begin
          strobe_d = 1'b1;
          oidx_d   = '0;
          ostart_d = '0;
          oend_d   = '0;
          ototal_d = '0;
          ostat_d  = status_q;
          olast_d  = 1'b1;
          state_d  = S_IDLE;
        end else begin
          if (pend_q) begin
            strobe_d = 1'b1;
            oidx_d   = isim_pkg::IndexW'(wtgt_q);
            ostart_d = rd_start;
            oend_d   = rd_end;
            ototal_d = isim_pkg::TotalW'(count_q);
            ostat_d  = status_q;
            olast_d  = (CW'(wtgt_q + 1'b1) == dump_n);
          end
          if (idx_q != dump_n) begin
            wtgt_d = idx_q;
            idx_d  = idx_q + 1'b1;
            pend_d = 1'b1;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      pend_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      pend_q   <= pend_d;
      strobe_q <= strobe_d;
    end
  end

  // Working and result payload, no reset needed.
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    wtgt_q   <= wtgt_d;
    first_q  <= first_d;
    past_q   <= past_d;
    found_q  <= found_d;
    merge_q  <= merge_d;
    ns_q     <= ns_d;
    ne_q     <= ne_d;
    fs_q     <= fs_d;
    le_q     <= le_d;
    status_q <= status_d;
    oidx_q   <= oidx_d;
    ostart_q <= ostart_d;
    oend_q   <= oend_d;
    ototal_q <= ototal_d;
    ostat_q  <= ostat_d;
    olast_q  <= olast_d;
  end

  assign busy          = (state_q != S_IDLE);
  assign strobe_o      = strobe_q;
  assign entry_index_o = oidx_q;
  assign entry_start_o = ostart_q;
  assign entry_end_o   = oend_q;
  assign entry_total_o = ototal_q;
  assign status_o      = ostat_q;
  assign last_o        = olast_q;

  // Results only follow a cycle of work.
  `ISIM_ASSERT(a_strobe_after_busy, !strobe_o || $past(busy), "result without request")
  // A dump runs without gaps until its last result.
  `ISIM_ASSERT_NEXT(a_dump_no_gap, strobe_o && !last_o, strobe_o, "gap in list dump")
  // The fill count never passes the table depth.
  `ISIM_ASSERT(a_count_bound, count_q <= CW'(TableDepth), "entry count overflow")
  // An accepted request holds the block busy.
  `ISIM_ASSERT_NEXT(a_busy_on_accept, start && !busy, busy, "request not taken")

endmodule
